// File: rtl/sdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdp_pkg
// widths, register indexes and pipeline context types shared by the sphere
// distance projection datapath
// ----------------------------------------------------------------------------
package sdp_pkg;

   localparam int COORD_W    = 32;   // signed q16.16 coordinate
   localparam int OFF_W      = 33;   // exact offset magnitude
   localparam int SQ_W       = 66;   // exact square and sum of squares
   localparam int DIST_W     = SQ_W / 2;
   localparam int RADIUS_W   = 31;   // clamped, non-negative radius
   localparam int NORM_W     = 16;   // q2.14 normal
   localparam int NORM_SHIFT = 14;
   localparam int VIOL_W     = 31;
   localparam int EPS_W      = 16;
   localparam int TOL_W      = 31;
   localparam int NUM_W      = 64;   // rounded dividend
   localparam int QUO_W      = 31;   // quotient bits per lane
   localparam int LANES      = 6;    // three position lanes, three normal lanes
   localparam int CSR_DATA_W = 31;

   typedef enum logic [0:0] {
      CSR_TOLERANCE = 1'b0,
      CSR_NEAR_ZERO = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] point;
      logic [2:0][COORD_W-1:0] pivot;
      logic [2:0][OFF_W-1:0]   mag;
      logic [2:0]              neg;
      logic [RADIUS_W-1:0]     radius;
   } geo_ctx_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] point;
      logic [2:0][COORD_W-1:0] pivot;
      logic [2:0]              neg;
      logic [RADIUS_W-1:0]     radius;
      logic [DIST_W-1:0]       span;
   } div_ctx_type;

endpackage
`default_nettype wire

// File: rtl/sdp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdp_req_if / sdp_rsp_if
// valid/ready channels carrying one projection request and one result
// ----------------------------------------------------------------------------
interface sdp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [31:0] pivot_x;
   logic signed [31:0] pivot_y;
   logic signed [31:0] pivot_z;
   logic signed [31:0] max_distance;

   modport source (output valid, point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
                   max_distance, input ready);
   modport sink (input valid, point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
                 max_distance, output ready);
endinterface

interface sdp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic [30:0]        violation;
   logic               at_limit;
   logic               constrained;

   modport source (output valid, out_x, out_y, out_z, normal_x, normal_y, normal_z,
                   violation, at_limit, constrained, input ready);
   modport sink (input valid, out_x, out_y, out_z, normal_x, normal_y, normal_z,
                 violation, at_limit, constrained, output ready);
endinterface
`default_nettype wire

// File: rtl/sdp_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdp_sqrt
// pipelined restoring integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module sdp_sqrt #(
   parameter int RAD_W = 66,
   parameter int SB_W  = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic [RAD_W-1:0]       in_rad,
   input  wire logic [SB_W-1:0]        in_sb,
   output logic                        out_valid,
   output logic [RAD_W/2-1:0]          out_root,
   output logic [SB_W-1:0]             out_sb
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 3;

   logic [ROOT_W-1:0]           v_ff;
   logic [RAD_W-1:0]            rad_ff  [ROOT_W];
   logic [REM_W-1:0]            rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]           root_ff [ROOT_W];
   logic [SB_W-1:0]             sb_ff   [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              v_cur;
      logic [RAD_W-1:0]  rad_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [SB_W-1:0]   sb_cur;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              ge;

      if (k == 0) begin : g_head
         // first stage takes the operand straight from the ports
         assign v_cur    = in_valid;
         assign rad_cur  = in_rad;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign sb_cur   = in_sb;
      end else begin : g_body
         assign v_cur    = v_ff[k-1];
         assign rad_cur  = rad_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign sb_cur   = sb_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_cur[REM_W-3:0], rad_cur[RAD_W-1 -: 2]};
         trial  = {1'b0, root_cur, 2'b01};
         ge     = (rem_sh >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_cur;
         end
         if (en) begin
            rad_ff[k]  <= {rad_cur[RAD_W-3:0], 2'b00};
            rem_ff[k]  <= ge ? rem_sh - trial : rem_sh;
            root_ff[k] <= {root_cur[ROOT_W-2:0], ge};
            sb_ff[k]   <= sb_cur;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_sb    = sb_ff[ROOT_W-1];

endmodule
`default_nettype wire

// File: rtl/sdp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdp_div
// pipelined restoring divider, several lanes over one shared divisor,
// one quotient bit per stage
// ----------------------------------------------------------------------------
module sdp_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 33,
   parameter int QUO_W = 31,
   parameter int LANES = 6,
   parameter int SB_W  = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [LANES-1:0][NUM_W-1:0]   in_num,
   input  wire logic [DEN_W-1:0]              in_den,
   input  wire logic [SB_W-1:0]               in_sb,
   output logic                               out_valid,
   output logic [LANES-1:0][QUO_W-1:0]        out_quo,
   output logic [SB_W-1:0]                    out_sb
);

   logic [QUO_W-1:0]                v_ff;
   logic [LANES-1:0][NUM_W-1:0]     rem_ff [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]     quo_ff [QUO_W];
   logic [DEN_W-1:0]                den_ff [QUO_W];
   logic [SB_W-1:0]                 sb_ff  [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic                         v_cur;
      logic [LANES-1:0][NUM_W-1:0]  rem_cur;
      logic [LANES-1:0][QUO_W-1:0]  quo_cur;
      logic [DEN_W-1:0]             den_cur;
      logic [SB_W-1:0]              sb_cur;
      logic [NUM_W-1:0]             dsh;
      logic [LANES-1:0][NUM_W-1:0]  rem_in;
      logic [LANES-1:0][QUO_W-1:0]  quo_in;

      if (k == 0) begin : g_head
         // first stage takes the operands straight from the ports
         assign v_cur   = in_valid;
         assign rem_cur = in_num;
         assign quo_cur = '0;
         assign den_cur = in_den;
         assign sb_cur  = in_sb;
      end else begin : g_body
         assign v_cur   = v_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign quo_cur = quo_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign sb_cur  = sb_ff[k-1];
      end

      always_comb begin
         dsh = {{(NUM_W-DEN_W){1'b0}}, den_cur} << (QUO_W - 1 - k);
         for (int l = 0; l < LANES; l++) begin
            if (rem_cur[l] >= dsh) begin
               rem_in[l] = rem_cur[l] - dsh;
               quo_in[l] = {quo_cur[l][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[l] = rem_cur[l];
               quo_in[l] = {quo_cur[l][QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_cur;
         end
         if (en) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            den_ff[k] <= den_cur;
            sb_ff[k]  <= sb_cur;
         end
      end
   end

   assign out_valid = v_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_sb    = sb_ff[QUO_W-1];

endmodule
`default_nettype wire

// File: rtl/sphere_distance_projection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_distance_projection
// keeps a 3d point within a maximum distance of a pivot, positions q16.16 throughout
// ----------------------------------------------------------------------------
// One request transaction enters per clock while the pipeline advances, and its
// response transaction leaves after offset, square, sum (3 stages), a 33-stage
// square root (one bit per stage), multiply and rounding bias (2 stages), a
// 31-stage divider that forms all six quotients at once (one bit per stage) and
// the output register. The whole pipeline advances together when the output
// register is empty or being taken; while the response is held, nothing
// moves and req.ready is low. Configuration writes are taken at any time but
// are only meant while the pipeline is empty.
// ----------------------------------------------------------------------------
module sphere_distance_projection
   import sdp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   sdp_req_if.sink                     req,
   sdp_rsp_if.source                   rsp,
   input  wire logic                   csr_we,
   input  wire csr_idx_type            csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // ---------------------------------------------------------------- control
   logic en;
   logic rsp_valid_ff;

   // whole pipeline moves when the output slot is free or being drained
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // ----------------------------------------------------------- csr storage
   logic [TOL_W-1:0] tol_ff;
   logic [EPS_W-1:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
         eps_ff <= EPS_W'(7);
      end else if (csr_we) begin
         case (csr_index)
            CSR_TOLERANCE: tol_ff <= csr_wdata[TOL_W-1:0];
            CSR_NEAR_ZERO: eps_ff <= csr_wdata[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------- stage 1: offsets
   geo_ctx_type           s1_in;
   geo_ctx_type           s1_ff;
   logic                  v1_ff;
   logic [2:0][OFF_W-1:0] off;

   always_comb begin
      s1_in.point = {req.point_z, req.point_y, req.point_x};
      s1_in.pivot = {req.pivot_z, req.pivot_y, req.pivot_x};
      for (int i = 0; i < 3; i++) begin
         // exact 33-bit difference
         off[i] = {s1_in.point[i][COORD_W-1], s1_in.point[i]}
                - {s1_in.pivot[i][COORD_W-1], s1_in.pivot[i]};
         s1_in.neg[i] = off[i][OFF_W-1];
         s1_in.mag[i] = off[i][OFF_W-1] ? OFF_W'(-off[i]) : off[i];
      end
      // negative radius clamps to zero
      s1_in.radius = req.max_distance[COORD_W-1] ? '0 : req.max_distance[RADIUS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
      end
      if (en) begin
         s1_ff <= s1_in;
      end
   end

   // ------------------------------------------------- stage 2: squares
   geo_ctx_type          s2_ff;
   logic                 v2_ff;
   logic [2:0][SQ_W-1:0] sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         s2_ff <= s1_ff;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SQ_W'(s1_ff.mag[i]) * SQ_W'(s1_ff.mag[i]);
         end
      end
   end

   // ------------------------------------------------- stage 3: sum of squares
   geo_ctx_type       s3_ff;
   logic              v3_ff;
   logic [SQ_W-1:0]   sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         s3_ff  <= s2_ff;
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   // ------------------------------------------------- square root pipeline
   logic              sq_valid;
   logic [DIST_W-1:0] span;
   geo_ctx_type       sq_ctx;

   sdp_sqrt #(
      .RAD_W (SQ_W),
      .SB_W  ($bits(geo_ctx_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_rad    (sum_ff),
      .in_sb     (s3_ff),
      .out_valid (sq_valid),
      .out_root  (span),
      .out_sb    (sq_ctx)
   );

   // ------------------------------------------------- stage p1: products
   div_ctx_type                   p1_ff;
   logic                          vp1_ff;
   logic [2:0][NUM_W-1:0]         prod_ff;
   logic [2:0][NUM_W-1:0]         nnum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp1_ff <= 1'b0;
      end else if (en) begin
         vp1_ff <= sq_valid;
      end
      if (en) begin
         p1_ff.point  <= sq_ctx.point;
         p1_ff.pivot  <= sq_ctx.pivot;
         p1_ff.neg    <= sq_ctx.neg;
         p1_ff.radius <= sq_ctx.radius;
         p1_ff.span   <= span;
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= NUM_W'(sq_ctx.mag[i]) * NUM_W'(sq_ctx.radius);
            nnum_ff[i] <= NUM_W'(sq_ctx.mag[i]) << NORM_SHIFT;
         end
      end
   end

   // ------------------------------------------------- stage p2: rounding bias
   div_ctx_type                   p2_ff;
   logic                          vp2_ff;
   logic [LANES-1:0][NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]              half;

   assign half = NUM_W'(p1_ff.span >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         vp2_ff <= 1'b0;
      end else if (en) begin
         vp2_ff <= vp1_ff;
      end
      if (en) begin
         p2_ff <= p1_ff;
         for (int i = 0; i < 3; i++) begin
            num_ff[i]     <= prod_ff[i] + half;
            num_ff[3 + i] <= nnum_ff[i] + half;
         end
      end
   end

   // ------------------------------------------------- divider pipeline
   logic                          dv_valid;
   logic [LANES-1:0][QUO_W-1:0]   quo;
   div_ctx_type                   dv_ctx;

   sdp_div #(
      .NUM_W (NUM_W),
      .DEN_W (DIST_W),
      .QUO_W (QUO_W),
      .LANES (LANES),
      .SB_W  ($bits(div_ctx_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vp2_ff),
      .in_num    (num_ff),
      .in_den    (p2_ff.span),
      .in_sb     (p2_ff),
      .out_valid (dv_valid),
      .out_quo   (quo),
      .out_sb    (dv_ctx)
   );

   // ------------------------------------------------- final stage: results
   logic [2:0][COORD_W-1:0]  pos_in;
   logic [2:0][NORM_W-1:0]   nrm_in;
   logic [VIOL_W-1:0]        viol_in;
   logic                     at_in;
   logic                     con_in;
   logic [2:0][OFF_W-1:0]    delta;
   logic [2:0][OFF_W-1:0]    moved;
   logic [2:0][COORD_W-1:0]  moved_sat;
   logic [2:0][NORM_W-1:0]   nrm_full;
   logic [DIST_W-1:0]        viol_raw;
   logic [VIOL_W-1:0]        viol_sat;
   logic [RADIUS_W-1:0]      band;
   logic                     near;
   logic                     con_n;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // signed step along the offset, then saturate pivot plus step
         delta[i] = dv_ctx.neg[i] ? OFF_W'(-{2'b00, quo[i]}) : {2'b00, quo[i]};
         moved[i] = {dv_ctx.pivot[i][COORD_W-1], dv_ctx.pivot[i]} + delta[i];
         if (moved[i][OFF_W-1] != moved[i][OFF_W-2]) begin
            moved_sat[i] = moved[i][OFF_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                             : {1'b0, {(COORD_W-1){1'b1}}};
         end else begin
            moved_sat[i] = moved[i][COORD_W-1:0];
         end
         nrm_full[i] = dv_ctx.neg[i] ? NORM_W'(-quo[3 + i][NORM_W-1:0])
                                     : quo[3 + i][NORM_W-1:0];
      end

      viol_raw = (dv_ctx.span > DIST_W'(dv_ctx.radius))
               ? dv_ctx.span - DIST_W'(dv_ctx.radius) : '0;
      viol_sat = (|viol_raw[DIST_W-1:VIOL_W]) ? '1 : viol_raw[VIOL_W-1:0];
      band     = (dv_ctx.radius > tol_ff) ? dv_ctx.radius - tol_ff : '0;
      near     = (dv_ctx.span <= DIST_W'(eps_ff));
      con_n    = (viol_sat > VIOL_W'(eps_ff));

      if (near) begin
         // point sits on the pivot: pass through, no direction
         pos_in  = dv_ctx.point;
         nrm_in  = '0;
         viol_in = '0;
         at_in   = (dv_ctx.radius <= tol_ff);
         con_in  = 1'b0;
      end else begin
         pos_in  = con_n ? moved_sat : dv_ctx.point;
         nrm_in  = nrm_full;
         viol_in = viol_sat;
         at_in   = con_n || (dv_ctx.span >= DIST_W'(band));
         con_in  = con_n;
      end
   end

   logic [2:0][COORD_W-1:0] pos_ff;
   logic [2:0][NORM_W-1:0]  nrm_ff;
   logic [VIOL_W-1:0]       viol_ff;
   logic                    at_ff;
   logic                    con_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
      if (en) begin
         pos_ff  <= pos_in;
         nrm_ff  <= nrm_in;
         viol_ff <= viol_in;
         at_ff   <= at_in;
         con_ff  <= con_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_x       = pos_ff[0];
   assign rsp.out_y       = pos_ff[1];
   assign rsp.out_z       = pos_ff[2];
   assign rsp.normal_x    = nrm_ff[0];
   assign rsp.normal_y    = nrm_ff[1];
   assign rsp.normal_z    = nrm_ff[2];
   assign rsp.violation   = viol_ff;
   assign rsp.at_limit    = at_ff;
   assign rsp.constrained = con_ff;

   // ------------------------------------------------------------ assertions
   a_con_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && con_ff |-> at_ff)
      else $error("constrained result without at_limit");

   a_con_violation: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && con_ff |-> (viol_ff > VIOL_W'(eps_ff)))
      else $error("constrained result with violation inside threshold");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(pos_ff) && $stable(viol_ff))
      else $error("held response changed while stalled");

   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !req.ready)
      else $error("request taken while pipeline stalled");

endmodule
`default_nettype wire

// File: bench/tb_sphere_distance_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_distance_projection
// self-checking bench for the sphere distance projection pipeline: requests
// come from a queue filled per configuration phase, a clocked driver and a
// clocked monitor apply random gaps and stalls, and every response is checked
// field by field against an in-bench projection predictor
// ----------------------------------------------------------------------------
module tb_sphere_distance_projection
   import sdp_pkg::*;
();

   // one request: point, pivot and radius, all signed q16.16
   typedef struct packed {
      logic [2:0][31:0] pt;
      logic [2:0][31:0] pv;
      logic [31:0]      r;
   } proj_req_type;

   // one response as the block should present it
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][15:0] nrm;
      logic [30:0]      viol;
      logic             at_lim;
      logic             moved;
   } proj_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sdp_req_if req_ch();
   sdp_rsp_if rsp_ch();

   sphere_distance_projection DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // mirror of the block's registers, updated only while the pipeline is empty
   logic [30:0] tol_cfg;
   logic [15:0] eps_cfg;

   proj_req_type pending_req[$];
   proj_rsp_type awaited_rsp[$];
   int           mismatches;
   bit           calm;          // phase with no idling on either side
   int           send_gap;
   int           take_stall;

   // ------------------------------------------------------------------------
   // projection predictor
   // ------------------------------------------------------------------------
   function automatic longint unsigned sqrt_floor(logic [69:0] s);
      logic [69:0] lo;
      logic [69:0] hi;
      logic [69:0] m;
      lo = '0;
      hi = 70'd1 << 34;
      while (hi - lo > 1) begin
         m = lo + ((hi - lo) >> 1);
         if (m * m <= s) lo = m;
         else hi = m;
      end
      return longint'(lo);
   endfunction

   // quotient rounded half away from zero
   function automatic longint round_div(longint num, longint unsigned den);
      logic [127:0] m;
      logic [127:0] q;
      m = (num < 0) ? 128'(-num) : 128'(num);
      q = (m + 128'(den / 2)) / 128'(den);
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic longint unsigned span_of(proj_req_type q);
      logic [69:0] ssq;
      longint      off;
      ssq = '0;
      for (int i = 0; i < 3; i++) begin
         off = longint'($signed(q.pt[i])) - longint'($signed(q.pv[i]));
         if (off < 0) off = -off;
         ssq += 70'(off) * 70'(off);
      end
      return sqrt_floor(ssq);
   endfunction

   function automatic proj_rsp_type project_point(proj_req_type q);
      proj_rsp_type    e;
      longint          off[3];
      longint unsigned span;
      longint unsigned rad;
      longint unsigned band;
      longint unsigned viol;
      rad = q.r[31] ? 0 : longint'(q.r);
      for (int i = 0; i < 3; i++)
         off[i] = longint'($signed(q.pt[i])) - longint'($signed(q.pv[i]));
      span     = span_of(q);
      e.pos    = q.pt;
      e.nrm    = '0;
      e.viol   = '0;
      e.moved  = 1'b0;
      // point sits on the pivot: pass through, no normal
      if (span <= longint'(eps_cfg)) begin
         e.at_lim = (rad <= longint'(tol_cfg));
         return e;
      end
      for (int i = 0; i < 3; i++)
         e.nrm[i] = 16'(round_div(off[i] * 16384, span));
      band     = (rad > tol_cfg) ? rad - tol_cfg : 0;
      viol     = (span > rad) ? span - rad : 0;
      e.at_lim = (span >= band);
      if (viol > 64'h7fff_ffff) viol = 64'h7fff_ffff;
      e.moved  = (viol > longint'(eps_cfg));
      if (e.moved) begin
         for (int i = 0; i < 3; i++)
            e.pos[i] = sat32(longint'($signed(q.pv[i])) + round_div(off[i] * longint'(rad), span));
         e.at_lim = 1'b1;
      end
      e.viol = viol[30:0];
      return e;
   endfunction

   // mostly short gaps, a few long ones, none in a calm phase
   function automatic int pick_gap();
      int u;
      if (calm) return 0;
      u = $urandom_range(0, 99);
      if (u < 60) return 0;
      if (u < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------------
   // clock, reset
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous limit: far above the slowest correct run
   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // driver: one request transaction per handshake, random gaps between
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid        <= 1'b0;
         req_ch.point_x      <= '0;
         req_ch.point_y      <= '0;
         req_ch.point_z      <= '0;
         req_ch.pivot_x      <= '0;
         req_ch.pivot_y      <= '0;
         req_ch.pivot_z      <= '0;
         req_ch.max_distance <= '0;
         send_gap            <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid)
            awaited_rsp.push_back(project_point({req_ch.point_x, req_ch.point_y,
               req_ch.point_z, req_ch.pivot_x, req_ch.pivot_y, req_ch.pivot_z,
               req_ch.max_distance}));
         if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_req.size() != 0) begin
            proj_req_type q;
            q = pending_req.pop_front();
            // packed order puts x in the top slice
            req_ch.point_x      <= q.pt[2];
            req_ch.point_y      <= q.pt[1];
            req_ch.point_z      <= q.pt[0];
            req_ch.pivot_x      <= q.pv[2];
            req_ch.pivot_y      <= q.pv[1];
            req_ch.pivot_z      <= q.pv[0];
            req_ch.max_distance <= q.r;
            req_ch.valid        <= 1'b1;
            send_gap            <= pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: compares each response transaction with the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_stall   <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            proj_rsp_type got;
            proj_rsp_type want;
            got = {rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.normal_x,
                   rsp_ch.normal_y, rsp_ch.normal_z, rsp_ch.violation,
                   rsp_ch.at_limit, rsp_ch.constrained};
            if (awaited_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response transaction at %0t", $realtime);
            end else begin
               want = awaited_rsp.pop_front();
               if (got.pos[2] !== want.pos[2] || got.pos[1] !== want.pos[1] ||
                   got.pos[0] !== want.pos[0] || got.nrm[2] !== want.nrm[2] ||
                   got.nrm[1] !== want.nrm[1] || got.nrm[0] !== want.nrm[0] ||
                   got.viol !== want.viol || got.at_lim !== want.at_lim ||
                   got.moved !== want.moved) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch at %0t", $realtime);
                     $display("  exp pos %h %h %h nrm %h %h %h viol %h lim %b mov %b",
                        want.pos[2], want.pos[1], want.pos[0], want.nrm[2], want.nrm[1],
                        want.nrm[0], want.viol, want.at_lim, want.moved);
                     $display("  got pos %h %h %h nrm %h %h %h viol %h lim %b mov %b",
                        got.pos[2], got.pos[1], got.pos[0], got.nrm[2], got.nrm[1],
                        got.nrm[0], got.viol, got.at_lim, got.moved);
                  end
               end
            end
         end
         // stall the response side now and then
         if (take_stall > 0) begin
            take_stall   <= take_stall - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            take_stall   <= pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic add_req(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                          logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                          logic [31:0] r);
      proj_req_type q;
      q.pt = {px, py, pz};
      q.pv = {vx, vy, vz};
      q.r  = r;
      pending_req.push_back(q);
   endtask

   // mostly points near the sphere surface, some pure noise
   task automatic add_random();
      proj_req_type    q;
      longint unsigned d;
      int              sel;
      sel = $urandom_range(0, 99);
      for (int i = 0; i < 3; i++) begin
         q.pv[i] = $urandom;
         if (sel < 15) q.pt[i] = $urandom;
         else if (sel < 22) q.pt[i] = q.pv[i] + 32'($urandom_range(0, 16)) - 32'd8;
         else q.pt[i] = q.pv[i] + 32'($signed($urandom) >>> $urandom_range(0, 31));
      end
      d = span_of(q);
      if (d > 64'h7fff_ffff) d = 64'h7fff_ffff;
      case ($urandom_range(0, 5))
         0:       q.r = $urandom;
         1:       q.r = 32'h8000_0000 | $urandom;
         2:       q.r = 32'(d >> $urandom_range(1, 8));
         default: begin
            // radius within a few lsb of the distance, or inside the band
            longint rr;
            rr = longint'(d) + $urandom_range(0, 40) - 20;
            if ($urandom_range(0, 3) == 0) rr = longint'(d) + longint'(tol_cfg >> 1);
            if (rr < 0) rr = 0;
            if (rr > 64'sh7fff_ffff) rr = 64'sh7fff_ffff;
            q.r = rr[31:0];
         end
      endcase
      pending_req.push_back(q);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [30:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_TOLERANCE) tol_cfg = v;
      else eps_cfg = v[15:0];
   endtask

   // pipeline empty: nothing queued, offered or outstanding
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_req.size() != 0 || req_ch.valid || awaited_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_TOLERANCE;
      csr_wdata           = '0;
      tol_cfg             = '0;
      eps_cfg             = 16'd7;
      mismatches          = 0;
      calm                = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed pass with reset register values
      add_req(0, 0, 0, 0, 0, 0, 0);                         // at pivot, zero radius
      add_req(32'h1234_5678, 32'hdead_beef, 5, 32'h1234_5678, 32'hdead_beef, 5, 100);
      add_req(5, 0, 0, 0, 0, 0, 32'hffff_fffb);             // inside epsilon, negative radius
      add_req(8, 0, 0, 0, 0, 0, 0);                         // just past epsilon
      add_req(0, 7, 0, 0, 0, 0, 0);                         // distance equal to epsilon
      add_req(32'h10000, 0, 0, 0, 0, 0, 32'h20000);         // well inside
      add_req(32'h30000, 32'h40000, 0, 0, 0, 0, 32'h50000); // on the boundary
      add_req(32'h30000, 32'h40000, 0, 0, 0, 0, 32'h4fff9); // violation equals epsilon
      add_req(32'h30000, 32'h40000, 0, 0, 0, 0, 32'h4fff8); // violation past epsilon
      add_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      add_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      add_req(32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000, 0,
              32'h8000_0000);                               // saturated violation
      add_req(32'hfffd_0000, 32'hfffc_0000, 0, 0, 0, 0, 32'h28000);
      add_req(32'h7fff_ffff, 32'h7fff_0000, 32'h7fff_fff0,
              32'h7fff_fff0, 32'h7fff_fff0, 32'h7fff_fff0, 32'h7fff_ffff);
      add_req(1, 1, 1, 32'hffff_fffe, 32'hffff_fffe, 32'hffff_fffe, 1);
      add_req(32'h0001_8000, 32'hffff_0000, 32'h0000_4000, 32'h0000_8000, 0, 0, 32'h8000);
      repeat (170) add_random();
      wait_idle();

      // further register settings, extremes among them
      for (int ph = 1; ph < 5; ph++) begin
         case (ph)
            1: begin
               write_csr(CSR_TOLERANCE, 31'd0);
               write_csr(CSR_NEAR_ZERO, 31'd0);
            end
            2: begin
               write_csr(CSR_TOLERANCE, 31'h7fff_ffff);
               write_csr(CSR_NEAR_ZERO, 31'h7fff_ffff);  // upper bits dropped
            end
            3: begin
               write_csr(CSR_TOLERANCE, 31'h3_0000);
               write_csr(CSR_NEAR_ZERO, 31'h1_0003);
            end
            default: begin
               write_csr(CSR_TOLERANCE, 31'($urandom));
               write_csr(CSR_NEAR_ZERO, 31'($urandom_range(0, 65535)));
            end
         endcase
         calm = (ph == 3);
         if (ph == 1) add_req(8, 0, 0, 0, 0, 0, 0);
         if (ph == 2) add_req(32'h7fff_ffff, 0, 0, 0, 0, 0, 32'h7fff_ffff);
         repeat (180) add_random();
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0 && awaited_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
